// ----- rtl/skf_pkg.sv -----
package skf_pkg;

  localparam logic [31:0] ONE_Q16   = 32'h0001_0000;
  localparam logic [16:0] GAIN_ONE  = 17'h1_0000;
  localparam int unsigned DIV_STEPS = 17;
  localparam int unsigned DIV_CNT_W = 5;

  typedef enum logic [2:0] {
    OP_UPD_GYRO  = 3'd0,
    OP_UPD       = 3'd1,
    OP_SET_NOISE = 3'd2,
    OP_RESET_ALL = 3'd3,
    OP_INIT      = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_PRED,
    ST_PRED_ACC,
    ST_DIV_START,
    ST_DIV,
    ST_GAIN,
    ST_GAIN_ACC,
    ST_COV_ACC,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    MUL_PRED,
    MUL_GAIN,
    MUL_COV
  } mul_sel_e;

  typedef struct packed {
    mul_sel_e mul_sel;
    logic     div_start;
    logic     cfg_we;
    logic     est_we;
    logic     cov_we;
    logic     out_load;
  } ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    logic signed [31:0] r;
    if (v > 37'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -37'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/skf_if.sv -----
interface skf_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         opcode;
  logic [2:0]         channel;
  logic signed [31:0] sample;
  logic signed [31:0] ang_rate;
  logic [15:0]        time_step;
  logic [23:0]        noise_q;
  logic [23:0]        noise_r;

  modport source (output valid, opcode, channel, sample, ang_rate, time_step, noise_q,
                  noise_r, input ready);
  modport sink (input valid, opcode, channel, sample, ang_rate, time_step, noise_q,
                noise_r, output ready);
endinterface

interface skf_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         channel_out;
  logic signed [31:0] estimate;
  logic [16:0]        gain;

  modport source (output valid, channel_out, estimate, gain, input ready);
  modport sink (input valid, channel_out, estimate, gain, output ready);
endinterface

// ----- rtl/skf_mul.sv -----
module skf_mul
  import skf_pkg::*;
(
  input  logic               clk_i,
  input  logic signed [33:0] a_i,
  input  logic signed [17:0] b_i,
  output logic signed [51:0] p_o
);

  logic signed [51:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= 52'(a_i) * 52'(b_i);
  end

  assign p_o = p_q;

endmodule

// ----- rtl/skf_div.sv -----
module skf_div
  import skf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [32:0] den_i,
  output logic        done_o,
  output logic [16:0] quot_o
);

  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 done_q;
  logic [33:0]          rem_q;
  logic [32:0]          den_q;
  logic [16:0]          quo_q;
  logic [34:0]          diff;
  logic                 ge;
  logic [33:0]          rem_sel;

  // restoring division, one quotient bit per cycle, msb first
  assign diff    = {1'b0, rem_q} - {2'b00, den_q};
  assign ge      = ~diff[34];
  assign rem_sel = ge ? diff[33:0] : rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= DIV_CNT_W'(DIV_STEPS);
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - 1'b1;
        done_q <= (cnt_q == DIV_CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {2'b00, num_i};
      den_q <= den_i;
      quo_q <= '0;
    end else if (cnt_q != '0) begin
      rem_q <= {rem_sel[32:0], 1'b0};
      quo_q <= {quo_q[15:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> cnt_q == '0)
    else $error("divider done while still stepping");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> quo_q <= GAIN_ONE)
    else $error("gain quotient above one");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> den_i != '0)
    else $error("divider started with zero divisor");

endmodule

// ----- rtl/multichannel_scalar_kalman_filter.sv -----
// an update with gyro runs the prediction before the gain division; a simple update skips the prediction
// the 17-step gain divider runs only for updates; a zero divisor skips it
// flow: one item at a time, taken only in idle; the next item is taken while a result waits
// reset: estimates and noise clear to zero, every covariance returns to 1.0
// reset is asynchronous and active low, no clearing pass
module multichannel_scalar_kalman_filter
  import skf_pkg::*;
#(
  parameter int CHANNELS = 6
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  skf_in_if.sink    in_i,
  skf_out_if.source out_o
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [4:0] CH_CNT = 5'(CHANNELS);

  state_e state_q, state_d;
  ctl_t   ctl;

  op_e                op_q;
  logic [2:0]         ch_q;
  logic signed [31:0] sample_q;
  logic signed [31:0] rate_q;
  logic [15:0]        dt_q;
  logic [23:0]        nq_q;
  logic [23:0]        nr_q;

  logic signed [31:0] est_q [CHANNELS];
  logic [31:0]        cov_q [CHANNELS];
  logic [23:0]        pq_q  [CHANNELS];
  logic [23:0]        pr_q  [CHANNELS];

  logic signed [31:0] xh_q;
  logic [31:0]        ph_q;
  logic signed [32:0] innov_q;
  logic [16:0]        k_q;

  logic               out_valid_q;
  logic [2:0]         out_ch_q;
  logic signed [31:0] out_est_q;
  logic [16:0]        out_gain_q;

  logic [IDX_W-1:0]   idx;
  logic               ch_ok;
  logic               is_upd;
  logic [32:0]        p_sum;
  logic [32:0]        den;
  logic               div_done;
  logic [16:0]        div_quot;
  logic signed [33:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [51:0] mul_p;
  logic signed [31:0] acc_sum;

  assign idx    = IDX_W'(ch_q);
  assign ch_ok  = {2'b00, ch_q} < CH_CNT;
  assign is_upd = (op_q == OP_UPD_GYRO) || (op_q == OP_UPD);
  assign p_sum  = {1'b0, cov_q[idx]} + {9'd0, pq_q[idx]};
  assign den    = {1'b0, ph_q} + {9'd0, pr_q[idx]};

  assign acc_sum = sat32({{5{xh_q[31]}}, xh_q} + {mul_p[51], mul_p[51:16]});

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (is_upd && ch_ok) begin
          state_d = (op_q == OP_UPD_GYRO) ? ST_PRED : ST_DIV_START;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_PRED:      state_d = ST_PRED_ACC;
      ST_PRED_ACC:  state_d = ST_DIV_START;
      ST_DIV_START: state_d = (den == '0) ? ST_GAIN : ST_DIV;
      ST_DIV: begin
        if (div_done) state_d = ST_GAIN;
      end
      ST_GAIN:      state_d = ST_GAIN_ACC;
      ST_GAIN_ACC:  state_d = ST_COV_ACC;
      ST_COV_ACC:   state_d = ST_DONE;
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) state_d = ST_IDLE;
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    ctl = '{mul_sel: MUL_PRED, div_start: 1'b0, cfg_we: 1'b0, est_we: 1'b0,
            cov_we: 1'b0, out_load: 1'b0};
    case (state_q)
      ST_LOAD:      ctl.cfg_we = 1'b1;
      ST_PRED:      ctl.mul_sel = MUL_PRED;
      ST_DIV_START: ctl.div_start = (den != '0);
      ST_GAIN:      ctl.mul_sel = MUL_GAIN;
      ST_GAIN_ACC: begin
        ctl.mul_sel = MUL_COV;
        ctl.est_we  = 1'b1;
      end
      ST_COV_ACC:   ctl.cov_we = 1'b1;
      ST_DONE:      ctl.out_load = !out_valid_q || out_o.ready;
      default:      ;
    endcase
  end

  always_comb begin
    case (ctl.mul_sel)
      MUL_PRED: begin
        mul_a = {{2{rate_q[31]}}, rate_q};
        mul_b = {2'b00, dt_q};
      end
      MUL_GAIN: begin
        mul_a = {innov_q[32], innov_q};
        mul_b = {1'b0, k_q};
      end
      MUL_COV: begin
        mul_a = {2'b00, ph_q};
        mul_b = {1'b0, GAIN_ONE - k_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  skf_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  skf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctl.div_start),
    .num_i   (ph_q),
    .den_i   (den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ctl.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        est_q[i] <= '0;
        cov_q[i] <= ONE_Q16;
        pq_q[i]  <= '0;
        pr_q[i]  <= '0;
      end
    end else begin
      if (ctl.cfg_we) begin
        if (op_q == OP_RESET_ALL) begin
          for (int i = 0; i < CHANNELS; i++) begin
            cov_q[i] <= ONE_Q16;
          end
        end else if (ch_ok && op_q == OP_SET_NOISE) begin
          pq_q[idx] <= nq_q;
          pr_q[idx] <= nr_q;
        end else if (ch_ok && op_q == OP_INIT) begin
          est_q[idx] <= sample_q;
          cov_q[idx] <= ONE_Q16;
          pq_q[idx]  <= nq_q;
          pr_q[idx]  <= nr_q;
        end
      end
      if (ctl.est_we) est_q[idx] <= acc_sum;
      if (ctl.cov_we) cov_q[idx] <= mul_p[47:16];
    end
  end

  // item capture and working registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_i.valid) begin
      op_q     <= op_e'(in_i.opcode);
      ch_q     <= in_i.channel;
      sample_q <= in_i.sample;
      rate_q   <= in_i.ang_rate;
      dt_q     <= in_i.time_step;
      nq_q     <= in_i.noise_q;
      nr_q     <= in_i.noise_r;
    end
    case (state_q)
      ST_LOAD: begin
        xh_q <= est_q[idx];
        ph_q <= p_sum[32] ? 32'hFFFF_FFFF : p_sum[31:0];
        k_q  <= '0;
      end
      ST_PRED_ACC: xh_q <= acc_sum;
      ST_DIV_START: begin
        innov_q <= {sample_q[31], sample_q} - {xh_q[31], xh_q};
        if (den == '0) k_q <= GAIN_ONE;
      end
      ST_DIV: begin
        if (div_done) k_q <= div_quot;
      end
      default: ;
    endcase
    if (ctl.out_load) begin
      out_ch_q   <= ch_q;
      out_est_q  <= ch_ok ? est_q[idx] : '0;
      out_gain_q <= k_q;
    end
  end

  assign in_i.ready        = (state_q == ST_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.channel_out = out_ch_q;
  assign out_o.estimate    = out_est_q;
  assign out_o.gain        = out_gain_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("gain quotient arrived outside division");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_COV_ACC |=> state_q == ST_DONE)
    else $error("covariance write not followed by result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !(is_upd && ch_ok)) |-> k_q == '0)
    else $error("nonzero gain on an item that is no update");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GAIN) |-> k_q <= GAIN_ONE)
    else $error("gain above one before estimate update");

endmodule
